/* hdl/dbrf_pkg.sv */
package dbrf_pkg;

  localparam int DEPTH   = 1024;
  localparam int MAX_RUN = 64;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 11;

  typedef enum logic [1:0] {
    REQ_PUSH      = 2'd0,
    REQ_POP       = 2'd1,
    REQ_POP_DELIM = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_e;

  typedef enum logic {
    CFG_DELIM = 1'b0,
    CFG_CAP   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    req_e              req_type;
    logic [BYTE_W-1:0] in_byte;
    logic [LEN_W-1:0]  max_len;
  } dbrf_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  fill_level;
  } dbrf_out_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } dbrf_mem_req_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] s;
    s = {1'b0, p} + CNT_W'(1);
    return (s >= cap) ? '0 : s[PTR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = CNT_W'(v);
    if (c == '0) begin
      return CNT_W'(1);
    end
    if (c > CNT_W'(DEPTH)) begin
      return CNT_W'(DEPTH);
    end
    return c;
  endfunction

endpackage

/* hdl/dbrf_ram.sv */
module dbrf_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/dbrf_ctrl.sv */
module dbrf_ctrl import dbrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dbrf_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dbrf_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  cfg_idx_e          cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output dbrf_mem_req_t     mem_req_o,
  input  logic [BYTE_W-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [BYTE_W-1:0] delim_q, delim_d;
  logic [LEN_W-1:0]  span_q, span_d;
  logic [LEN_W-1:0]  iss_q, iss_d;
  logic [LEN_W-1:0]  chk_q, chk_d;
  logic [LEN_W-1:0]  iss_rem_q, iss_rem_d;
  logic [LEN_W-1:0]  emit_rem_q, emit_rem_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  dbrf_out_t         out_q, out_d;

  logic              out_free;
  logic              hit;
  logic              load;
  logic              issue;
  logic [LEN_W-1:0]  lim;
  logic [LEN_W-1:0]  avail;
  logic [LEN_W-1:0]  chk_inc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign lim        = (in_data_i.max_len > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN)
                                                           : in_data_i.max_len;
  assign avail      = (count_q < CNT_W'(lim)) ? count_q[LEN_W-1:0] : lim;
  assign chk_inc    = chk_q + LEN_W'(1);
  assign hit        = pend_q && (mem_rdata_i == delim_q);
  assign load       = (state_q == ST_EMIT) && pend_q && out_free;
  assign issue      = (state_q == ST_EMIT) && (iss_rem_q != '0) && (!pend_q || load);

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    scan_ptr_d  = scan_ptr_q;
    count_d     = count_q;
    cap_d       = cap_q;
    delim_d     = delim_q;
    span_d      = span_q;
    iss_d       = iss_q;
    chk_d       = chk_q;
    iss_rem_d   = iss_rem_q;
    emit_rem_d  = emit_rem_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_req_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          case (in_data_i.req_type)
            REQ_PUSH: begin
              if (count_q < cap_q) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = wr_ptr_q;
                mem_req_o.wdata = in_data_i.in_byte;
                wr_ptr_d        = next_ptr(wr_ptr_q, cap_q);
                count_d         = count_q + CNT_W'(1);
                out_d.accepted  = 1'b1;
              end
              out_d.fill_level = count_d;
            end
            REQ_CLEAR: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              count_d  = '0;
              out_d.fill_level = '0;
            end
            REQ_POP: begin
              out_d.fill_level = count_q;
              if (avail != '0) begin
                out_valid_d = out_valid_q && !out_ready_i;
                out_d       = out_q;
                iss_rem_d   = avail;
                emit_rem_d  = avail;
                pend_d      = 1'b0;
                state_d     = ST_EMIT;
              end
            end
            default: begin
              out_d.fill_level = count_q;
              if (avail != '0) begin
                out_valid_d = out_valid_q && !out_ready_i;
                out_d       = out_q;
                span_d      = avail;
                scan_ptr_d  = rd_ptr_q;
                iss_d       = '0;
                chk_d       = '0;
                pend_d      = 1'b0;
                state_d     = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          iss_rem_d  = chk_inc;
          emit_rem_d = chk_inc;
          pend_d     = 1'b0;
          state_d    = ST_EMIT;
        end else begin
          if (pend_q) begin
            chk_d = chk_inc;
          end
          if (pend_q && (chk_inc == span_q)) begin
            pend_d  = 1'b0;
            state_d = ST_EMPTY;
          end else if (iss_q < span_q) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = scan_ptr_q;
            scan_ptr_d      = next_ptr(scan_ptr_q, cap_q);
            iss_d           = iss_q + LEN_W'(1);
            pend_d          = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d      = 1'b1;
          out_d            = '0;
          out_d.out_byte   = mem_rdata_i;
          out_d.byte_valid = 1'b1;
          out_d.last       = (emit_rem_q == LEN_W'(1));
          count_d          = count_q - CNT_W'(1);
          out_d.fill_level = count_d;
          emit_rem_d       = emit_rem_q - LEN_W'(1);
          pend_d           = 1'b0;
          if (emit_rem_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = rd_ptr_q;
          rd_ptr_d        = next_ptr(rd_ptr_q, cap_q);
          iss_rem_d       = iss_rem_q - LEN_W'(1);
          pend_d          = 1'b1;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d            = '0;
          out_d.last       = 1'b1;
          out_d.fill_level = count_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DELIM: begin
          delim_d = cfg_wdata_i[BYTE_W-1:0];
        end
        default: begin
          cap_d    = eff_cap(cfg_wdata_i);
          rd_ptr_d = '0;
          wr_ptr_d = '0;
          count_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      cap_q       <= CNT_W'(DEPTH);
      delim_q     <= BYTE_W'(10);
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      delim_q     <= delim_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    span_q     <= span_d;
    iss_q      <= iss_d;
    chk_q      <= chk_d;
    iss_rem_q  <= iss_rem_d;
    emit_rem_q <= emit_rem_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/delimited_byte_ring_fifo.sv */
// Byte ring FIFO with delimiter framing.
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one request per
// transfer: push a byte, pop up to max_len bytes (at most 64), pop through the
// delimiter, or clear. The output channel (out_valid_o, out_ready_i, out_data_o)
// returns one result per removed byte, or a single empty result, with last on
// the final one. A push or clear gives its result in the cycle after the
// transfer. A plain pop reads its first byte into the output register, then
// gives one byte per cycle. A delimiter pop first scans the frame through the
// store at one byte per cycle, then emits like a plain pop. The single read
// port of the byte store sets these rates. A new request is taken once the
// last result of the previous one is in the output register and that register
// is empty or being taken. When the receiver stalls, the output register holds
// its result and the run pauses without losing a byte. The config port writes
// the delimiter or the capacity; a capacity write also empties the buffer.
// Reset empties the buffer, sets the delimiter to 10 and the capacity to 1024.
// Store contents are not cleared; only entries written by pushes are read.
module delimited_byte_ring_fifo import dbrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dbrf_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dbrf_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  dbrf_mem_req_t     mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  dbrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  dbrf_ram #(
    .Depth (DEPTH),
    .Width (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* hdl/dbrf_checker.sv */
module dbrf_checker import dbrf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input dbrf_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Output changed while stalled.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.last && out_data_o.out_byte == '0)
    else $error("Empty result is not a zero last result.");

  a_accept_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> !out_data_o.byte_valid && out_data_o.last)
    else $error("Push acknowledgment carries a byte.");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fill_level <= CNT_W'(DEPTH))
    else $error("Fill level beyond depth.");

endmodule

bind delimited_byte_ring_fifo dbrf_checker u_dbrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
